// ===== src/hdtr_pkg.sv =====
package hdtr_pkg;

    localparam int OP_W  = 28;
    localparam int ACC_W = 48;

    localparam logic signed [16:0] HALF_TURN    = 17'sd18000;
    localparam logic signed [16:0] FULL_TURN    = 17'sd36000;
    localparam logic signed [16:0] QUARTER_TURN = 17'sd9000;
    localparam logic [14:0]        HALF_TURN_U  = 15'd18000;

    localparam logic signed [15:0] ONE_Q14       = 16'sd16384;
    localparam logic signed [16:0] TRIM_LIMIT    = 17'sd20480;
    localparam logic [7:0]         TIMEOUT_RESET = 8'd60;

    // parabola: p = floor((x * 256 + PAR_BIAS) / PAR_DIV), x = m * (18000 - m)
    localparam logic signed [ACC_W-1:0] PAR_BIAS  = 48'sd632812;
    localparam logic signed [ACC_W-1:0] PAR_DIV   = 48'sd1265625;
    localparam logic signed [OP_W-1:0]  PAR_NDIV  = -28'sd1265625;
    localparam logic signed [OP_W-1:0]  PAR_RECIP = 28'sd55599995;  // 2^46 / PAR_DIV

    // refinement: s = floor((p * (POLY_BASE + 9p) + POLY_BIAS) / 2^16 / 10)
    localparam logic [19:0]             POLY_BASE = 20'd507904;
    localparam logic signed [ACC_W-1:0] POLY_BIAS = 48'sd327680;

    // floor(v / 10) = (v * RECIP_DEC) >> 19, floor(w / 5) = (w * RECIP_DEC) >> 18
    localparam logic signed [OP_W-1:0]  RECIP_DEC  = 28'sd52429;
    localparam logic [30:0]             ROUND_BIAS = 31'd163840;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_X,
        ST_QEST,
        ST_REM,
        ST_POLY,
        ST_DEC,
        ST_R1,
        ST_R2,
        ST_QR,
        ST_P1,
        ST_P2,
        ST_QP,
        ST_DONE
    } hdtr_state_t;

    typedef enum logic {
        REG_HEADLESS = 1'b0,
        REG_TIMEOUT  = 1'b1
    } hdtr_reg_t;

    typedef struct packed {
        logic signed [15:0] stick_pitch;
        logic signed [15:0] stick_roll;
        logic signed [15:0] yaw_angle;
        logic               headless;
    } hdtr_job_t;

    typedef struct packed {
        logic idle;
        logic done;
    } hdtr_stat_t;

    typedef struct packed {
        logic signed [12:0] d_pitch;
        logic signed [12:0] d_roll;
    } hdtr_delta_t;

    function automatic logic signed [15:0] wrap_angle(input logic signed [16:0] h);
        logic signed [16:0] t;
        if (h >= HALF_TURN)
            t = h - FULL_TURN;
        else if (h < -HALF_TURN)
            t = h + FULL_TURN;
        else
            t = h;
        return t[15:0];
    endfunction

endpackage

// ===== src/hdtr_mac.sv =====
module hdtr_mac (
    input  logic signed [hdtr_pkg::OP_W-1:0]  op_a,
    input  logic signed [hdtr_pkg::OP_W-1:0]  op_b,
    input  logic signed [hdtr_pkg::ACC_W-1:0] op_c,
    output logic signed [hdtr_pkg::ACC_W-1:0] res
);
    import hdtr_pkg::*;

    logic signed [2*OP_W-1:0] prod;

    always_comb
    begin
        prod = op_a * op_b;
        res  = prod[ACC_W-1:0] + op_c;
    end

endmodule

// ===== src/hdtr_core.sv =====
module hdtr_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  hdtr_pkg::hdtr_job_t   job,
    input  logic                  ack,
    output hdtr_pkg::hdtr_stat_t  stat,
    output hdtr_pkg::hdtr_delta_t delta
);
    import hdtr_pkg::*;

    hdtr_state_t state_reg, state_next;
    logic        cos_reg, cos_next;

    hdtr_job_t          job_reg, job_next;
    logic signed [15:0] yaw_reg, yaw_next;
    logic [34:0]        z_reg, z_next;
    logic [14:0]        qe_reg, qe_next;
    logic [14:0]        p_reg, p_next;
    logic [17:0]        v_reg, v_next;
    logic signed [15:0] s_reg, s_next;
    logic signed [15:0] c_reg, c_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [12:0] dr_reg, dr_next;
    logic signed [12:0] dp_reg, dp_next;

    logic signed [OP_W-1:0]  mac_a, mac_b;
    logic signed [ACC_W-1:0] mac_c, mac_res;

    logic signed [15:0] ang;
    logic               ang_neg;
    logic signed [15:0] ang_abs;
    logic [14:0]        m;
    logic [14:0]        m_comp;
    logic [19:0]        poly_b;
    logic [14:0]        sine_mag;
    logic signed [15:0] sine;
    logic               rnd_neg;
    logic signed [ACC_W-1:0] rnd_abs;
    logic [30:0]        rnd_sum;
    logic [14:0]        rnd_w;
    logic [11:0]        rnd_q;
    logic signed [12:0] rnd_d;

    hdtr_mac u_mac (
        .op_a (mac_a),
        .op_b (mac_b),
        .op_c (mac_c),
        .res  (mac_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cos_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cos_reg   <= cos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        yaw_reg <= yaw_next;
        z_reg   <= z_next;
        qe_reg  <= qe_next;
        p_reg   <= p_next;
        v_reg   <= v_next;
        s_reg   <= s_next;
        c_reg   <= c_next;
        acc_reg <= acc_next;
        dr_reg  <= dr_next;
        dp_reg  <= dp_next;
    end

    always_comb
    begin
        ang      = cos_reg ? wrap_angle({yaw_reg[15], yaw_reg} + QUARTER_TURN) : yaw_reg;
        ang_neg  = ang[15];
        ang_abs  = ang_neg ? -ang : ang;
        m        = ang_abs[14:0];
        m_comp   = HALF_TURN_U - m;
        poly_b   = POLY_BASE + {p_reg, 3'b000} + {5'b0, p_reg};
        sine_mag = mac_res[33:19];
        sine     = ang_neg ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

        rnd_neg  = acc_reg[ACC_W-1];
        rnd_abs  = rnd_neg ? -acc_reg : acc_reg;
        rnd_sum  = rnd_abs[30:0] + ROUND_BIAS;
        rnd_w    = rnd_sum[30:16];
        rnd_q    = mac_res[29:18];
        rnd_d    = rnd_neg ? -$signed({1'b0, rnd_q}) : $signed({1'b0, rnd_q});
    end

    always_comb
    begin
        state_next = state_reg;
        cos_next   = cos_reg;
        job_next   = job_reg;
        yaw_next   = yaw_reg;
        z_next     = z_reg;
        qe_next    = qe_reg;
        p_next     = p_reg;
        v_next     = v_reg;
        s_next     = s_reg;
        c_next     = c_reg;
        acc_next   = acc_reg;
        dr_next    = dr_reg;
        dp_next    = dp_reg;
        mac_a      = '0;
        mac_b      = '0;
        mac_c      = '0;
        stat.idle  = 1'b0;
        stat.done  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                stat.idle = 1'b1;
                if (start)
                begin
                    job_next = job;
                    yaw_next = wrap_angle({job.yaw_angle[15], job.yaw_angle});
                    cos_next = 1'b0;
                    c_next   = ONE_Q14;
                    s_next   = '0;
                    state_next = job.headless ? ST_X : ST_R1;
                end
            end
            ST_X:
            begin
                mac_a      = $signed({13'b0, m});
                mac_b      = $signed({5'b0, m_comp, 8'b0});
                mac_c      = PAR_BIAS;
                z_next     = mac_res[34:0];
                state_next = ST_QEST;
            end
            ST_QEST:
            begin
                mac_a      = $signed({7'b0, z_reg[34:14]});
                mac_b      = PAR_RECIP;
                qe_next    = mac_res[46:32];
                state_next = ST_REM;
            end
            ST_REM:
            begin
                mac_a      = $signed({13'b0, qe_reg});
                mac_b      = PAR_NDIV;
                mac_c      = $signed({13'b0, z_reg});
                p_next     = (mac_res >= PAR_DIV) ? qe_reg + 15'd1 : qe_reg;
                state_next = ST_POLY;
            end
            ST_POLY:
            begin
                mac_a      = $signed({13'b0, p_reg});
                mac_b      = $signed({8'b0, poly_b});
                mac_c      = POLY_BIAS;
                v_next     = mac_res[33:16];
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                mac_a = $signed({10'b0, v_reg});
                mac_b = RECIP_DEC;
                if (!cos_reg)
                begin
                    s_next     = sine;
                    cos_next   = 1'b1;
                    state_next = ST_X;
                end
                else
                begin
                    c_next     = sine;
                    state_next = ST_R1;
                end
            end
            ST_R1:
            begin
                mac_a      = OP_W'(job_reg.stick_roll);
                mac_b      = OP_W'(c_reg);
                acc_next   = mac_res;
                state_next = ST_R2;
            end
            ST_R2:
            begin
                mac_a      = OP_W'(job_reg.stick_pitch);
                mac_b      = -OP_W'(s_reg);
                mac_c      = acc_reg;
                acc_next   = mac_res;
                state_next = ST_QR;
            end
            ST_QR:
            begin
                mac_a      = $signed({13'b0, rnd_w});
                mac_b      = RECIP_DEC;
                dr_next    = rnd_d;
                state_next = ST_P1;
            end
            ST_P1:
            begin
                mac_a      = OP_W'(job_reg.stick_pitch);
                mac_b      = OP_W'(c_reg);
                acc_next   = mac_res;
                state_next = ST_P2;
            end
            ST_P2:
            begin
                mac_a      = OP_W'(job_reg.stick_roll);
                mac_b      = OP_W'(s_reg);
                mac_c      = acc_reg;
                acc_next   = mac_res;
                state_next = ST_QP;
            end
            ST_QP:
            begin
                mac_a      = $signed({13'b0, rnd_w});
                mac_b      = RECIP_DEC;
                dp_next    = rnd_d;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                stat.done = 1'b1;
                if (ack)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign delta.d_pitch = dp_reg;
    assign delta.d_roll  = dr_reg;

endmodule

// ===== src/headless_trim_rotator.sv =====
// Trim accumulator with optional headless rotation. Each input item adds one
// fifth of the stick deflection (Q2.14 into Q4.12) to the pitch and roll
// trims, clamped to +/-5.0, and returns the new trims with a leave_screen flag.
// With headless_mode set, the stick is first rotated by the yaw angle using a
// parabolic sine with one refinement step. All products are formed by a single
// 28x28 multiply-accumulate unit under a step sequencer, one product per cycle;
// sine and cosine need five products each in headless mode, and the two rotated
// sums need six. The result sits in an output register, so the next item is
// taken while it waits; the block stalls only when a finished result cannot be
// handed over.
module headless_trim_rotator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // stick_pitch, stick_roll, yaw_angle, exit_key, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // trim_pitch_out, trim_roll_out, leave_screen, zero pad
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import hdtr_pkg::*;

    logic        headless_reg;
    logic [7:0]  limit_reg;
    logic signed [15:0] pitch_trim_reg, pitch_trim_next;
    logic signed [15:0] roll_trim_reg, roll_trim_next;
    logic [7:0]  tick_reg, tick_next;
    logic        key_reg;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;

    hdtr_job_t   job;
    hdtr_stat_t  stat;
    hdtr_delta_t delta;
    logic        accept;
    logic        ack;
    logic [7:0]  tick_inc;
    logic        leave;
    logic signed [16:0] pitch_sum;
    logic signed [16:0] roll_sum;
    logic signed [16:0] pitch_clamp;
    logic signed [16:0] roll_clamp;

    assign job.stick_pitch = $signed(s_tdata[15:0]);
    assign job.stick_roll  = $signed(s_tdata[31:16]);
    assign job.yaw_angle   = $signed(s_tdata[47:32]);
    assign job.headless    = headless_reg;

    assign s_tready = stat.idle;
    assign accept   = s_tvalid && stat.idle;
    assign ack      = stat.done && (!m_tvalid_reg || m_tready);

    hdtr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .job   (job),
        .ack   (ack),
        .stat  (stat),
        .delta (delta)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            headless_reg   <= 1'b0;
            limit_reg      <= TIMEOUT_RESET;
            pitch_trim_reg <= '0;
            roll_trim_reg  <= '0;
            tick_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (hdtr_reg_t'(cfg_addr))
                    REG_HEADLESS: headless_reg <= cfg_wdata[0];
                    REG_TIMEOUT:  limit_reg    <= cfg_wdata;
                    default:      limit_reg    <= limit_reg;
                endcase
            end
            pitch_trim_reg <= pitch_trim_next;
            roll_trim_reg  <= roll_trim_next;
            tick_reg       <= tick_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        if (accept)
            key_reg <= s_tdata[48];
    end

    always_comb
    begin
        tick_inc  = tick_reg + 8'd1;
        leave     = key_reg || (tick_inc > limit_reg);
        pitch_sum = {pitch_trim_reg[15], pitch_trim_reg} + 17'(delta.d_pitch);
        roll_sum  = {roll_trim_reg[15], roll_trim_reg} + 17'(delta.d_roll);

        if (pitch_sum > TRIM_LIMIT)
            pitch_clamp = TRIM_LIMIT;
        else if (pitch_sum < -TRIM_LIMIT)
            pitch_clamp = -TRIM_LIMIT;
        else
            pitch_clamp = pitch_sum;

        if (roll_sum > TRIM_LIMIT)
            roll_clamp = TRIM_LIMIT;
        else if (roll_sum < -TRIM_LIMIT)
            roll_clamp = -TRIM_LIMIT;
        else
            roll_clamp = roll_sum;

        pitch_trim_next = pitch_trim_reg;
        roll_trim_next  = roll_trim_reg;
        tick_next       = tick_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        if (ack)
        begin
            pitch_trim_next = pitch_clamp[15:0];
            roll_trim_next  = roll_clamp[15:0];
            tick_next       = leave ? 8'd0 : tick_inc;
            m_tvalid_next   = 1'b1;
            m_tdata_next    = {7'b0, leave, roll_clamp[15:0], pitch_clamp[15:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/hdtr_chk.sv =====
module hdtr_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd20480) &&
                     ($signed(m_tdata[15:0]) >= -16'sd20480))
        else $error("pitch trim out of range");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd20480) &&
                     ($signed(m_tdata[31:16]) >= -16'sd20480))
        else $error("roll trim out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after an accepted item");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in progress");

endmodule

bind headless_trim_rotator hdtr_chk u_hdtr_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

// ===== tb/headless_trim_rotator_test.sv =====
module headless_trim_rotator_test;

    localparam int HALF_TURN_CD   = 18000;
    localparam int FULL_TURN_CD   = 36000;
    localparam int QUARTER_CD     = 9000;
    localparam int UNITY_Q14      = 16384;
    localparam int TRIM_BOUND     = 20480;
    localparam int STICK_SCALE    = 327680;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RANDOM_PER_MIX = 120;

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic               leave;
    } trim_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_addr = '0;
    logic [7:0]  cfg_wdata = '0;

    // model state
    logic               rotate_on;
    logic [7:0]         leave_limit;
    logic signed [15:0] pitch_acc;
    logic signed [15:0] roll_acc;
    logic [7:0]         tick;

    trim_result_t trim_queue[$];
    int error_count = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_len = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    headless_trim_rotator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int fold_angle(input int h);
        return (h + HALF_TURN_CD + 2 * FULL_TURN_CD) % FULL_TURN_CD - HALF_TURN_CD;
    endfunction

    function automatic longint parabolic_sine(input int h);
        longint m;
        longint p;
        m = (h < 0) ? -h : h;
        p = (m * (HALF_TURN_CD - m) * 65536 + 162000000) / 324000000;
        p = (p * (31 * UNITY_Q14 + 9 * p) + 327680) / 655360;
        return (h < 0) ? -p : p;
    endfunction

    function automatic longint scale_stick(input longint num);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + STICK_SCALE / 2) / STICK_SCALE;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] bound_trim(input longint v);
        if (v > TRIM_BOUND)
            return 16'(TRIM_BOUND);
        if (v < -TRIM_BOUND)
            return 16'(-TRIM_BOUND);
        return v[15:0];
    endfunction

    function automatic trim_result_t advance_trims(input logic signed [15:0] sp,
                                                   input logic signed [15:0] sr,
                                                   input logic signed [15:0] yaw,
                                                   input logic key);
        trim_result_t res;
        longint c;
        longint s;
        longint p;
        longint r;
        int a;
        c = UNITY_Q14;
        s = 0;
        p = sp;
        r = sr;
        a = fold_angle(int'(yaw));
        if (rotate_on)
        begin
            s = parabolic_sine(a);
            c = parabolic_sine(fold_angle(a + QUARTER_CD));
        end
        roll_acc = bound_trim(longint'(roll_acc) + scale_stick(r * c - p * s));
        pitch_acc = bound_trim(longint'(pitch_acc) + scale_stick(p * c + r * s));
        res.leave = key;
        if (!key)
        begin
            tick = tick + 8'd1;
            res.leave = tick > leave_limit;
        end
        if (res.leave)
            tick = '0;
        res.pitch = pitch_acc;
        res.roll = roll_acc;
        return res;
    endfunction

    task automatic send_item(input logic signed [15:0] sp, input logic signed [15:0] sr,
                             input logic signed [15:0] yaw, input logic key);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, key, yaw, sr, sp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        trim_queue.push_back(advance_trims(sp, sr, yaw, key));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (trim_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input hdtr_pkg::hdtr_reg_t idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == hdtr_pkg::REG_HEADLESS)
            rotate_on = value[0];
        else
            leave_limit = value;
    endtask

    task automatic configure(input logic headless, input logic [7:0] limit);
        drain();
        write_reg(hdtr_pkg::REG_HEADLESS, {7'b0, headless});
        write_reg(hdtr_pkg::REG_TIMEOUT, limit);
    endtask

    task automatic send_random(input int drift);
        logic signed [15:0] sp;
        logic signed [15:0] sr;
        logic signed [15:0] yaw;
        logic key;
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            sp = 16'($urandom());
            sr = 16'($urandom());
            yaw = 16'($urandom());
        end
        else if (pick == 1)
        begin
            sp = 16'(int'($urandom_range(4)) * 16384 - 32768);
            sr = 16'(int'($urandom_range(4)) * 16384 - 32768);
            yaw = 16'(int'($urandom_range(8)) * 4500 - 18000);
            if (sp == 16'sh8000 + 16'sd0 && $urandom_range(1))
                sp = 16'sh7fff;
        end
        else
        begin
            sp = 16'(int'($urandom_range(32768)) - 16384);
            sr = 16'(int'($urandom_range(32768)) - 16384);
            yaw = 16'(int'($urandom_range(36000)) - 18000);
        end
        // push the trims toward one rail now and then
        if ($urandom_range(9) < 3)
        begin
            sp = 16'(drift * 16384);
            sr = 16'(-drift * 16384);
        end
        key = ($urandom_range(24) == 0);
        send_item(sp, sr, yaw, key);
    endtask

    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        trim_result_t want;
        logic signed [15:0] got_pitch;
        logic signed [15:0] got_roll;
        logic got_leave;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_pitch = m_tdata[15:0];
            got_roll = m_tdata[31:16];
            got_leave = m_tdata[32];
            if (trim_queue.size() == 0)
            begin
                $display("%0t unexpected item: pitch %0d roll %0d leave %0b",
                         $time, got_pitch, got_roll, got_leave);
                error_count++;
            end
            else
            begin
                want = trim_queue.pop_front();
                if (got_pitch !== want.pitch)
                begin
                    $display("%0t trim_pitch_out: expected %0d, got %0d",
                             $time, want.pitch, got_pitch);
                    error_count++;
                end
                if (got_roll !== want.roll)
                begin
                    $display("%0t trim_roll_out: expected %0d, got %0d",
                             $time, want.roll, got_roll);
                    error_count++;
                end
                if (got_leave !== want.leave)
                begin
                    $display("%0t leave_screen: expected %0b, got %0b",
                             $time, want.leave, got_leave);
                    error_count++;
                end
            end
        end
    end

    task automatic test_straight_sticks();
        configure(1'b0, 8'd60);
        send_item(16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_item(16'sd16384, -16'sd16384, 16'sd0, 1'b0);
        send_item(16'sd10, -16'sd10, 16'sd0, 1'b0);
        send_item(-16'sd10, 16'sd30, 16'sd0, 1'b0);
        // drive both trims into their rails
        repeat (13) send_item(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
        send_item(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1);
    endtask

    task automatic test_headless_angles();
        configure(1'b1, 8'd60);
        send_item(16'sd16384, 16'sd0, 16'sd0, 1'b0);
        send_item(16'sd16384, 16'sd8192, 16'sd9000, 1'b0);
        send_item(-16'sd16384, 16'sd16384, -16'sd9000, 1'b0);
        send_item(16'sd12000, -16'sd5000, 16'sd18000, 1'b0);
        send_item(16'sd12000, -16'sd5000, -16'sd18000, 1'b0);
        send_item(16'sd7000, 16'sd7000, 16'sd4500, 1'b0);
        send_item(16'sd16384, -16'sd16384, 16'sh7fff, 1'b0);
        send_item(-16'sd16384, 16'sd16384, 16'sh8000, 1'b1);
    endtask

    task automatic test_key_and_timeout();
        configure(1'b0, 8'd0);
        repeat (4) send_item(16'sd100, 16'sd200, 16'sd0, 1'b0);
        send_item(16'sd100, 16'sd200, 16'sd0, 1'b1);
        configure(1'b0, 8'd3);
        repeat (9) send_item(-16'sd300, 16'sd300, 16'sd0, 1'b0);
        // count runs with no timeout at a limit of 255; random exit keys reset it
        configure(1'b1, 8'd255);
        repeat (260) send_random(0);
    endtask

    task automatic test_random_traffic();
        int mix;
        int hl;
        int drift;
        logic [7:0] limit;
        for (mix = 0; mix < 4; mix++)
        begin
            for (hl = 0; hl < 2; hl++)
            begin
                case ($urandom_range(5))
                    0: limit = 8'd0;
                    1: limit = 8'd255;
                    2: limit = 8'd60;
                    3: limit = 8'd5;
                    default: limit = 8'($urandom_range(40));
                endcase
                configure(hl[0], limit);
                send_idle_pct = (mix == 1 || mix == 3) ? ((mix == 3) ? 13 : 73) : 0;
                recv_stall_pct = (mix == 2 || mix == 3) ? ((mix == 3) ? 13 : 73) : 0;
                drift = $urandom_range(1) ? 1 : -1;
                repeat (RANDOM_PER_MIX) send_random(drift);
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        configure(1'b1, 8'd20);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 400;
        hold_seq = hold_seq + 1;
        repeat (40) send_random(1);
    endtask

    task automatic test_pause_until_drained();
        configure(1'b1, 8'd10);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        repeat (12) send_random(-1);
        drain();
        repeat (12) send_random(1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rotate_on = 1'b0;
        leave_limit = 8'd60;
        pitch_acc = '0;
        roll_acc = '0;
        tick = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_straight_sticks();
        test_headless_angles();
        test_key_and_timeout();
        test_random_traffic();
        test_backpressure();
        test_pause_until_drained();
        drain();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/hdtr_pkg.sv
src/hdtr_mac.sv
src/hdtr_core.sv
src/headless_trim_rotator.sv
src/hdtr_chk.sv
tb/headless_trim_rotator_test.sv
